FILE: rtl/core/drum_note_dispatcher_macros.svh
// ----------------------------------------------------------------------------
// Drum note dispatcher assertion macros
// Concurrent assertion wrappers, compiled to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef DRUM_NOTE_DISPATCHER_MACROS_SVH
`define DRUM_NOTE_DISPATCHER_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every rising edge outside reset.
`define DND_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dnd assertion failed");
// Checked at every rising edge, reset included.
`define DND_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("dnd assertion failed");
`else
`define DND_ASSERT(label, clk, rst_n, prop)
`define DND_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: rtl/core/dnd_pkg.sv
// ----------------------------------------------------------------------------
// Drum note dispatcher package
// Widths, codes, key and velocity lookup tables shared by the core.
// ----------------------------------------------------------------------------
package dnd_pkg;

    localparam int KEY_W   = 7;
    localparam int VEL_W   = 7;
    localparam int CNT_W   = 3;
    localparam int CHIP_W  = 2;
    localparam int INST_W  = 3;
    localparam int LVL_W   = 5;
    localparam int GRP_W   = 3;

    localparam logic [KEY_W-1:0] KEY_FIRST = 7'd35;
    localparam logic [KEY_W-1:0] KEY_LAST  = 7'd88;
    localparam int               KEY_COUNT = 54;

    localparam logic [INST_W-1:0] INST_NONE = 3'd7;
    localparam logic [GRP_W-1:0]  GRP_NONE  = 3'd0;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_MUTE   = 2'd1,
        ST_PLAYED = 2'd2
    } t_status;

    typedef struct packed {
        logic              damp;
        logic [INST_W-1:0] inst;
    } t_choke;

    localparam logic [INST_W-1:0] INST_OF_KEY [KEY_COUNT] = '{
        3'd0, 3'd0, 3'd5, 3'd1, 3'd5, 3'd1, 3'd4, 3'd3, 3'd4, 3'd3,
        3'd4, 3'd3, 3'd4, 3'd4, 3'd2, 3'd4, 3'd3, 3'd2, 3'd2, 3'd3,
        3'd2, 3'd7, 3'd2, 3'd7, 3'd3, 3'd4, 3'd4, 3'd5, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd3, 3'd3,
        3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7,
        3'd7,
        3'd3, 3'd3, 3'd3,
        3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7
    };

    localparam logic [LVL_W-1:0] LEVEL_OF_VEL [128] = '{
        5'd0,  5'd4,  5'd7,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd15,
        5'd16, 5'd16, 5'd17, 5'd17, 5'd18, 5'd18, 5'd18, 5'd19, 5'd19, 5'd19, 5'd20,
        5'd20, 5'd20, 5'd21, 5'd21, 5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd22,
        5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24,
        5'd24, 5'd24, 5'd25, 5'd25, 5'd25, 5'd25, 5'd25, 5'd25, 5'd25, 5'd25, 5'd26,
        5'd26, 5'd26, 5'd26, 5'd26, 5'd26, 5'd26, 5'd26, 5'd26, 5'd27, 5'd27, 5'd27,
        5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd28, 5'd28, 5'd28,
        5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd29, 5'd29,
        5'd29, 5'd29, 5'd29, 5'd29, 5'd29, 5'd29, 5'd29, 5'd29, 5'd29, 5'd29, 5'd29,
        5'd29, 5'd29, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30,
        5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd31, 5'd31, 5'd31,
        5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31
    };

    function automatic logic [INST_W-1:0] inst_of(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] offs;
        offs = key - KEY_FIRST;
        if (key < KEY_FIRST || key > KEY_LAST) begin
            return INST_NONE;
        end
        return INST_OF_KEY[offs[5:0]];
    endfunction

    // Choke group 1..5, or GRP_NONE.
    function automatic logic [GRP_W-1:0] group_of(input logic [KEY_W-1:0] key);
        case (key)
            7'd42, 7'd44, 7'd46: return 3'd1;
            7'd71, 7'd72:        return 3'd2;
            7'd73, 7'd74:        return 3'd3;
            7'd78, 7'd79:        return 3'd4;
            7'd80, 7'd81:        return 3'd5;
            default:             return GRP_NONE;
        endcase
    endfunction

endpackage

FILE: rtl/core/drum_note_dispatcher.sv
// ----------------------------------------------------------------------------
// Drum note dispatcher
// Turns percussion note-on items into damp and key-on commands for a set
// of rhythm sound chips, with choke groups and round-robin chip rotation.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries key and velocity; output
// channel (o_out_valid / i_out_ready) carries one result item per input item:
// status, optional damp (chip, instrument) and optional key-on (chip,
// instrument, level). Unused command fields read as zero.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes chip_count;
// it is always ready; the user writes it only while idle, not enforced here.
// An accepted item sits in the input register, is decoded and lands in the
// result register once that register is free, and its result is then
// offered. One item per cycle is sustained while i_out_ready stays high;
// decode, choke lookup and chip rotation are combinational between them.
// Reset clears chip rotation, the choke memory (no remembered notes) and sets
// chip_count to 1. When the receiver stalls, the result register holds and
// the input register takes one more item, then o_in_ready falls.
// ----------------------------------------------------------------------------
`include "drum_note_dispatcher_macros.svh"

module drum_note_dispatcher #(
    parameter int MAX_CHIPS    = 4,
    parameter int CHOKE_GROUPS = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dnd_pkg::CNT_W-1:0]     i_cfg_chip_count,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dnd_pkg::KEY_W-1:0]     i_key,
    input  logic [dnd_pkg::VEL_W-1:0]     i_velocity,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic                          o_damp_valid,
    output logic [dnd_pkg::CHIP_W-1:0]    o_damp_chip,
    output logic [dnd_pkg::INST_W-1:0]    o_damp_instrument,
    output logic                          o_keyon_valid,
    output logic [dnd_pkg::CHIP_W-1:0]    o_keyon_chip,
    output logic [dnd_pkg::INST_W-1:0]    o_keyon_instrument,
    output logic [dnd_pkg::LVL_W-1:0]     o_inst_level
);

    localparam logic [dnd_pkg::CNT_W-1:0]   MaxChipsC = dnd_pkg::CNT_W'(MAX_CHIPS);
    localparam logic [dnd_pkg::GRP_W:0]     ChokeC    = (dnd_pkg::GRP_W + 1)'(CHOKE_GROUPS);

    // Configuration
    logic [dnd_pkg::CNT_W-1:0] r_chip_count;

    // Input register
    logic                      r_in_valid;
    logic [dnd_pkg::KEY_W-1:0] r_key;
    logic [dnd_pkg::VEL_W-1:0] r_vel;

    // Chip rotation
    logic [dnd_pkg::CHIP_W-1:0] r_cur_chip;
    logic [dnd_pkg::CHIP_W-1:0] r_prev_chip;

    // Result register
    logic                        r_out_valid;
    dnd_pkg::t_status            r_status;
    logic                        r_damp_valid;
    logic [dnd_pkg::CHIP_W-1:0]  r_damp_chip;
    logic [dnd_pkg::INST_W-1:0]  r_damp_inst;
    logic                        r_keyon_valid;
    logic [dnd_pkg::CHIP_W-1:0]  r_keyon_chip;
    logic [dnd_pkg::INST_W-1:0]  r_keyon_inst;
    logic [dnd_pkg::LVL_W-1:0]   r_level;

    logic                        advance;
    logic                        fire;
    logic                        in_acc;
    logic [dnd_pkg::CNT_W-1:0]   n_eff;
    logic                        chips_on;
    logic [dnd_pkg::CHIP_W-1:0]  cur;
    logic [dnd_pkg::CHIP_W-1:0]  prev;
    logic [dnd_pkg::CNT_W-1:0]   cur_inc;
    logic [dnd_pkg::CHIP_W-1:0]  n_cur_chip;
    logic [dnd_pkg::GRP_W-1:0]   grp;
    logic [dnd_pkg::GRP_W-1:0]   slot;
    logic                        grp_on;
    logic [dnd_pkg::INST_W-1:0]  inst;
    logic                        play;
    dnd_pkg::t_choke             choke;

    dnd_pkg::t_status            n_status;
    logic                        n_damp_valid;
    logic [dnd_pkg::CHIP_W-1:0]  n_damp_chip;
    logic [dnd_pkg::INST_W-1:0]  n_damp_inst;
    logic                        n_keyon_valid;
    logic [dnd_pkg::CHIP_W-1:0]  n_keyon_chip;
    logic [dnd_pkg::INST_W-1:0]  n_keyon_inst;
    logic [dnd_pkg::LVL_W-1:0]   n_level;

    assign o_cfg_ready = 1'b1;
    assign advance     = !r_out_valid || i_out_ready;
    assign fire        = r_in_valid && advance;
    assign o_in_ready  = !r_in_valid || advance;
    assign in_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_eff    = (r_chip_count > MaxChipsC) ? MaxChipsC : r_chip_count;
        chips_on = (n_eff != '0);
        // Stale indices after a lowered chip count fall back to chip 0
        cur      = (dnd_pkg::CNT_W'(r_cur_chip)  < n_eff) ? r_cur_chip  : '0;
        prev     = (dnd_pkg::CNT_W'(r_prev_chip) < n_eff) ? r_prev_chip : '0;
        cur_inc  = dnd_pkg::CNT_W'(cur) + 3'd1;
        n_cur_chip = (cur_inc == n_eff) ? '0 : cur_inc[dnd_pkg::CHIP_W-1:0];

        grp    = dnd_pkg::group_of(r_key);
        slot   = grp - 3'd1;
        grp_on = chips_on && (grp != dnd_pkg::GRP_NONE)
                 && ((dnd_pkg::GRP_W + 1)'(grp) <= ChokeC);

        inst   = dnd_pkg::inst_of(r_key);
        play   = chips_on && (inst != dnd_pkg::INST_NONE) && (r_vel != '0);

        n_damp_valid = grp_on && choke.damp;
        n_damp_chip  = n_damp_valid ? prev : '0;
        n_damp_inst  = n_damp_valid ? choke.inst : '0;

        n_keyon_valid = play;
        n_keyon_chip  = play ? cur  : '0;
        n_keyon_inst  = play ? inst : '0;
        n_level       = play ? dnd_pkg::LEVEL_OF_VEL[r_vel] : '0;

        if (!chips_on || inst == dnd_pkg::INST_NONE) begin
            n_status = dnd_pkg::ST_NONE;
        end else if (r_vel == '0) begin
            n_status = dnd_pkg::ST_MUTE;
        end else begin
            n_status = dnd_pkg::ST_PLAYED;
        end
    end

    dnd_choke #(
        .CHOKE_GROUPS (CHOKE_GROUPS)
    ) u_choke (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slot  (slot),
        .i_key   (r_key),
        .i_upd   (fire && grp_on),
        .o_choke (choke)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_count <= 3'd1;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cur_chip   <= '0;
            r_prev_chip  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_chip_count <= i_cfg_chip_count;
            end
            // Hold the input item until the result register frees up
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // Advance round robin only on a played note
            if (fire && play) begin
                r_prev_chip <= cur;
                r_cur_chip  <= n_cur_chip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key <= i_key;
            r_vel <= i_velocity;
        end
        if (fire) begin
            r_status      <= n_status;
            r_damp_valid  <= n_damp_valid;
            r_damp_chip   <= n_damp_chip;
            r_damp_inst   <= n_damp_inst;
            r_keyon_valid <= n_keyon_valid;
            r_keyon_chip  <= n_keyon_chip;
            r_keyon_inst  <= n_keyon_inst;
            r_level       <= n_level;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_damp_valid       = r_damp_valid;
    assign o_damp_chip        = r_damp_chip;
    assign o_damp_instrument  = r_damp_inst;
    assign o_keyon_valid      = r_keyon_valid;
    assign o_keyon_chip       = r_keyon_chip;
    assign o_keyon_instrument = r_keyon_inst;
    assign o_inst_level       = r_level;

    `DND_ASSERT(a_keyon_status, i_clk, i_rst_n, r_out_valid |-> (r_keyon_valid == (r_status == dnd_pkg::ST_PLAYED)))
    `DND_ASSERT(a_keyon_level, i_clk, i_rst_n, (r_out_valid && r_keyon_valid) |-> (r_level != '0))
    `DND_ASSERT(a_keyon_idle, i_clk, i_rst_n, (r_out_valid && !r_keyon_valid) |-> (r_level == '0 && r_keyon_inst == '0 && r_keyon_chip == '0))
    `DND_ASSERT(a_damp_inst, i_clk, i_rst_n, (r_out_valid && r_damp_valid) |-> (r_damp_inst != dnd_pkg::INST_NONE && r_status != dnd_pkg::ST_NONE || r_damp_inst != dnd_pkg::INST_NONE))
    `DND_ASSERT(a_chip_range, i_clk, i_rst_n, (dnd_pkg::CNT_W'(r_cur_chip) < MaxChipsC) && (dnd_pkg::CNT_W'(r_prev_chip) < MaxChipsC))
    `DND_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> (!r_in_valid && !r_out_valid))

endmodule

FILE: rtl/core/dnd_choke.sv
// ----------------------------------------------------------------------------
// Choke group memory
// Remembers the last key of each choke group and flags a damp when a
// different, mapped key of the same group was heard before.
// ----------------------------------------------------------------------------
module dnd_choke #(
    parameter int CHOKE_GROUPS = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [dnd_pkg::GRP_W-1:0]    i_slot,
    input  logic [dnd_pkg::KEY_W-1:0]    i_key,
    input  logic                         i_upd,
    output dnd_pkg::t_choke              o_choke
);

    logic [CHOKE_GROUPS-1:0] r_grp_valid;
    logic [dnd_pkg::KEY_W-1:0] r_grp_key [CHOKE_GROUPS];

    logic                      hit_valid;
    logic [dnd_pkg::KEY_W-1:0] hit_key;
    logic [dnd_pkg::INST_W-1:0] hit_inst;

    always_comb begin
        hit_valid = 1'b0;
        hit_key   = '0;
        for (int g = 0; g < CHOKE_GROUPS; g++) begin
            if (i_slot == dnd_pkg::GRP_W'(g)) begin
                hit_valid = r_grp_valid[g];
                hit_key   = r_grp_key[g];
            end
        end
        hit_inst      = dnd_pkg::inst_of(hit_key);
        o_choke.damp  = hit_valid && (hit_key != i_key) && (hit_inst != dnd_pkg::INST_NONE);
        o_choke.inst  = hit_inst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_valid <= '0;
        end else if (i_upd) begin
            for (int g = 0; g < CHOKE_GROUPS; g++) begin
                if (i_slot == dnd_pkg::GRP_W'(g)) begin
                    r_grp_valid[g] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd) begin
            for (int g = 0; g < CHOKE_GROUPS; g++) begin
                if (i_slot == dnd_pkg::GRP_W'(g)) begin
                    r_grp_key[g] <= i_key;
                end
            end
        end
    end

endmodule

FILE: bench/drum_note_dispatcher_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drum note dispatcher checker
// Watches the configuration, note and command channels of the dispatcher,
// predicts the command item for every accepted note from its own copy of
// the choke memory and chip rotation, and compares field by field.
// ----------------------------------------------------------------------------
module drum_note_dispatcher_checker #(
    parameter int MAX_CHIPS    = 4,
    parameter int CHOKE_GROUPS = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [dnd_pkg::CNT_W-1:0]     i_cfg_chip_count,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [dnd_pkg::KEY_W-1:0]     i_key,
    input  logic [dnd_pkg::VEL_W-1:0]     i_velocity,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [1:0]                    i_status,
    input  logic                          i_damp_valid,
    input  logic [dnd_pkg::CHIP_W-1:0]    i_damp_chip,
    input  logic [dnd_pkg::INST_W-1:0]    i_damp_instrument,
    input  logic                          i_keyon_valid,
    input  logic [dnd_pkg::CHIP_W-1:0]    i_keyon_chip,
    input  logic [dnd_pkg::INST_W-1:0]    i_keyon_instrument,
    input  logic [dnd_pkg::LVL_W-1:0]     i_inst_level,
    output int                            o_errors,
    output int                            o_pending
);

    localparam logic [2:0] DRUM_BASS   = 3'd0;
    localparam logic [2:0] DRUM_SNARE  = 3'd1;
    localparam logic [2:0] DRUM_CYMBAL = 3'd2;
    localparam logic [2:0] DRUM_HIHAT  = 3'd3;
    localparam logic [2:0] DRUM_TOM    = 3'd4;
    localparam logic [2:0] DRUM_RIM    = 3'd5;

    // First velocity of each level step from 16 upwards.
    localparam logic [16*7-1:0] LEVEL_STEPS = {
        7'd118, 7'd101, 7'd86, 7'd74, 7'd63, 7'd54, 7'd46, 7'd39,
        7'd33,  7'd28,  7'd24, 7'd21, 7'd18, 7'd15, 7'd13, 7'd11
    };

    typedef struct packed {
        dnd_pkg::t_status               status;
        logic                           damp;
        logic [dnd_pkg::CHIP_W-1:0]     damp_chip;
        logic [dnd_pkg::INST_W-1:0]     damp_inst;
        logic                           keyon;
        logic [dnd_pkg::CHIP_W-1:0]     keyon_chip;
        logic [dnd_pkg::INST_W-1:0]     keyon_inst;
        logic [dnd_pkg::LVL_W-1:0]      level;
    } t_dispatch;

    t_dispatch                       dispatch_q[$];
    logic [dnd_pkg::CNT_W-1:0]       chip_count;
    logic [dnd_pkg::CHIP_W-1:0]      rr_chip;
    logic [dnd_pkg::CHIP_W-1:0]      last_chip;
    logic                            held_valid [8];
    logic [dnd_pkg::KEY_W-1:0]       held_key [8];
    int                              errors;

    function automatic logic [2:0] drum_of(input logic [6:0] key);
        case (key)
            7'd35, 7'd36:                                 return DRUM_BASS;
            7'd38, 7'd40:                                 return DRUM_SNARE;
            7'd49, 7'd52, 7'd53, 7'd55, 7'd57:            return DRUM_CYMBAL;
            7'd42, 7'd44, 7'd46, 7'd51, 7'd54, 7'd59,
            7'd67, 7'd68, 7'd80, 7'd81, 7'd82:            return DRUM_HIHAT;
            7'd41, 7'd43, 7'd45, 7'd47, 7'd48, 7'd50,
            7'd60, 7'd61, 7'd63, 7'd64:                   return DRUM_TOM;
            7'd37, 7'd39, 7'd62, 7'd65, 7'd66:            return DRUM_RIM;
            default:                                      return dnd_pkg::INST_NONE;
        endcase
    endfunction

    function automatic int choke_group(input logic [6:0] key);
        case (key)
            7'd42, 7'd44, 7'd46: return 1;
            7'd71, 7'd72:        return 2;
            7'd73, 7'd74:        return 3;
            7'd78, 7'd79:        return 4;
            7'd80, 7'd81:        return 5;
            default:             return 0;
        endcase
    endfunction

    function automatic logic [4:0] loudness(input logic [6:0] vel);
        logic [4:0] lvl;
        case (vel)
            7'd0: return 5'd0;
            7'd1: return 5'd4;
            7'd2: return 5'd7;
            7'd3: return 5'd9;
            default: ;
        endcase
        if (vel < 7'd10) begin
            return 5'(vel) + 5'd6;
        end
        lvl = 5'd15;
        for (int i = 0; i < 16; i++) begin
            if (vel >= LEVEL_STEPS[i*7 +: 7]) begin
                lvl = lvl + 5'd1;
            end
        end
        return lvl;
    endfunction

    // Work out the command item for one note and advance the local state.
    function automatic t_dispatch dispatch_note(input logic [6:0] key, input logic [6:0] vel);
        t_dispatch                  r;
        int                         n;
        int                         grp;
        logic [dnd_pkg::CHIP_W-1:0] cur;
        logic [dnd_pkg::CHIP_W-1:0] prev;
        logic [2:0]                 drum;
        r = '0;
        r.status = dnd_pkg::ST_NONE;
        n = (chip_count > MAX_CHIPS) ? MAX_CHIPS : int'(chip_count);
        if (n != 0) begin
            // a chip index left over from a larger count falls back to chip 0
            cur  = (rr_chip < n) ? rr_chip : '0;
            prev = (last_chip < n) ? last_chip : '0;
            grp = choke_group(key);
            if (grp != 0 && grp <= CHOKE_GROUPS) begin
                if (held_valid[grp-1] && held_key[grp-1] != key) begin
                    drum = drum_of(held_key[grp-1]);
                    if (drum != dnd_pkg::INST_NONE) begin
                        r.damp      = 1'b1;
                        r.damp_chip = prev;
                        r.damp_inst = drum;
                    end
                end
                held_valid[grp-1] = 1'b1;
                held_key[grp-1]   = key;
            end
            drum = drum_of(key);
            if (drum != dnd_pkg::INST_NONE) begin
                if (vel == '0) begin
                    r.status = dnd_pkg::ST_MUTE;
                end else begin
                    r.status     = dnd_pkg::ST_PLAYED;
                    r.keyon      = 1'b1;
                    r.keyon_chip = cur;
                    r.keyon_inst = drum;
                    r.level      = loudness(vel);
                    last_chip    = cur;
                    rr_chip      = dnd_pkg::CHIP_W'((int'(cur) + 1) % n);
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_dispatch want;
        t_dispatch fresh;
        if (!i_rst_n) begin
            dispatch_q.delete();
            chip_count = 3'd1;
            rr_chip    = '0;
            last_chip  = '0;
            for (int i = 0; i < 8; i++) begin
                held_valid[i] = 1'b0;
                held_key[i]   = '0;
            end
            errors = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (dispatch_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected command item: st=%0d damp=%0d/%0d/%0d keyon=%0d/%0d/%0d lvl=%0d",
                                 i_status, i_damp_valid, i_damp_chip, i_damp_instrument,
                                 i_keyon_valid, i_keyon_chip, i_keyon_instrument, i_inst_level);
                    end
                end else begin
                    want = dispatch_q.pop_front();
                    if (i_status !== want.status || i_damp_valid !== want.damp
                            || i_damp_chip !== want.damp_chip
                            || i_damp_instrument !== want.damp_inst
                            || i_keyon_valid !== want.keyon
                            || i_keyon_chip !== want.keyon_chip
                            || i_keyon_instrument !== want.keyon_inst
                            || i_inst_level !== want.level) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch at %0t: expected st=%0d damp=%0d/%0d/%0d keyon=%0d/%0d/%0d lvl=%0d",
                                     $realtime, want.status, want.damp, want.damp_chip,
                                     want.damp_inst, want.keyon, want.keyon_chip,
                                     want.keyon_inst, want.level);
                            $display("                 got st=%0d damp=%0d/%0d/%0d keyon=%0d/%0d/%0d lvl=%0d",
                                     i_status, i_damp_valid, i_damp_chip, i_damp_instrument,
                                     i_keyon_valid, i_keyon_chip, i_keyon_instrument,
                                     i_inst_level);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                fresh      = dispatch_note(i_key, i_velocity);
                dispatch_q = {dispatch_q, fresh};
            end
            if (i_cfg_valid && i_cfg_ready) begin
                chip_count = i_cfg_chip_count;
            end
        end
        o_errors  <= errors;
        o_pending <= dispatch_q.size();
    end

endmodule

FILE: bench/drum_note_dispatcher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drum note dispatcher testbench
// Drives directed and random note items through several chip counts, with
// random idling on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module drum_note_dispatcher_test;

    localparam int          MAX_CHIPS    = 4;
    localparam int          CHOKE_GROUPS = 5;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          PHASE_ITEMS  = 206;

    localparam logic [11*7-1:0] CHOKE_KEYS = {
        7'd81, 7'd80, 7'd79, 7'd78, 7'd74, 7'd73, 7'd72, 7'd71, 7'd46, 7'd44, 7'd42
    };
    // Chip count of each random phase, lowest field first.
    localparam logic [8*3-1:0] PHASE_COUNTS = {
        3'd4, 3'd0, 3'd5, 3'd1, 3'd7, 3'd2, 3'd3, 3'd4
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [dnd_pkg::CNT_W-1:0]     i_cfg_chip_count;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [dnd_pkg::KEY_W-1:0]     i_key;
    logic [dnd_pkg::VEL_W-1:0]     i_velocity;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [1:0]                    o_status;
    logic                          o_damp_valid;
    logic [dnd_pkg::CHIP_W-1:0]    o_damp_chip;
    logic [dnd_pkg::INST_W-1:0]    o_damp_instrument;
    logic                          o_keyon_valid;
    logic [dnd_pkg::CHIP_W-1:0]    o_keyon_chip;
    logic [dnd_pkg::INST_W-1:0]    o_keyon_instrument;
    logic [dnd_pkg::LVL_W-1:0]     o_inst_level;

    int          errors;
    int          pending;
    logic        idle_on;
    int unsigned cycle_count = 0;

    drum_note_dispatcher #(
        .MAX_CHIPS    (MAX_CHIPS),
        .CHOKE_GROUPS (CHOKE_GROUPS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_chip_count   (i_cfg_chip_count),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_key              (i_key),
        .i_velocity         (i_velocity),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_damp_valid       (o_damp_valid),
        .o_damp_chip        (o_damp_chip),
        .o_damp_instrument  (o_damp_instrument),
        .o_keyon_valid      (o_keyon_valid),
        .o_keyon_chip       (o_keyon_chip),
        .o_keyon_instrument (o_keyon_instrument),
        .o_inst_level       (o_inst_level)
    );

    drum_note_dispatcher_checker #(
        .MAX_CHIPS    (MAX_CHIPS),
        .CHOKE_GROUPS (CHOKE_GROUPS)
    ) checker_inst (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_chip_count   (i_cfg_chip_count),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_key              (i_key),
        .i_velocity         (i_velocity),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_status           (o_status),
        .i_damp_valid       (o_damp_valid),
        .i_damp_chip        (o_damp_chip),
        .i_damp_instrument  (o_damp_instrument),
        .i_keyon_valid      (o_keyon_valid),
        .i_keyon_chip       (o_keyon_chip),
        .i_keyon_instrument (o_keyon_instrument),
        .i_inst_level       (o_inst_level),
        .o_errors           (errors),
        .o_pending          (pending)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= idle_on ? ($urandom_range(99) >= 11) : 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("drum_note_dispatcher_test: FAIL");
            $finish;
        end
    end

    // Offer one note item, optionally after a gap with valid low, and hold it until taken.
    task automatic send_note(input logic [6:0] key, input logic [6:0] vel);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(99) < 11) begin
            gap = 1;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_key      <= key;
        i_velocity <= vel;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop the note channel and wait for every command item to come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_chip_count(input logic [2:0] count);
        settle();
        i_cfg_valid      <= 1'b1;
        i_cfg_chip_count <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [6:0] k;
        logic [6:0] v;
        int         sel;
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_chip_count = '0;
        i_in_valid       = 1'b0;
        i_key            = '0;
        i_velocity       = '0;
        idle_on          = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // one chip out of reset: key range edges, zero velocity, choke groups
        send_note(7'd0, 7'd0);
        send_note(7'd127, 7'd127);
        send_note(7'd34, 7'd64);
        send_note(7'd35, 7'd127);
        send_note(7'd88, 7'd1);
        send_note(7'd89, 7'd90);
        send_note(7'd36, 7'd0);
        send_note(7'd42, 7'd100);
        send_note(7'd46, 7'd64);
        send_note(7'd46, 7'd3);
        send_note(7'd44, 7'd0);
        send_note(7'd71, 7'd50);
        send_note(7'd72, 7'd50);
        send_note(7'd80, 7'd127);
        send_note(7'd81, 7'd9);
        send_note(7'd38, 7'd2);
        send_note(7'd49, 7'd85);
        send_note(7'd41, 7'd118);
        send_note(7'd37, 7'd10);

        // rotate to chip 3, then shrink the count so both indexes go stale
        set_chip_count(3'd4);
        send_note(7'd35, 7'd60);
        send_note(7'd38, 7'd61);
        send_note(7'd42, 7'd62);
        set_chip_count(3'd2);
        send_note(7'd46, 7'd90);
        set_chip_count(3'd7);
        send_note(7'd81, 7'd33);
        send_note(7'd80, 7'd34);
        set_chip_count(3'd0);
        send_note(7'd42, 7'd70);
        send_note(7'd46, 7'd71);

        for (int p = 0; p < 8; p++) begin
            set_chip_count(PHASE_COUNTS[p*3 +: 3]);
            idle_on = (p != 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                sel = $urandom_range(99);
                if (sel < 30) begin
                    k = CHOKE_KEYS[$urandom_range(10)*7 +: 7];
                end else if (sel < 80) begin
                    k = 7'($urandom_range(88, 35));
                end else begin
                    k = 7'($urandom_range(127));
                end
                sel = $urandom_range(99);
                if (sel < 15) begin
                    v = '0;
                end else if (sel < 25) begin
                    v = 7'd127;
                end else begin
                    v = 7'($urandom_range(127));
                end
                send_note(k, v);
            end
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("drum_note_dispatcher_test: PASS");
        end else begin
            $display("drum_note_dispatcher_test: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/dnd_pkg.sv
rtl/core/dnd_choke.sv
rtl/core/drum_note_dispatcher.sv
bench/drum_note_dispatcher_checker.sv
bench/drum_note_dispatcher_test.sv
